// ===== src/vefe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vefe_pkg
// Shared types, constants and helpers of the voxel exposed-face extractor.
// ----------------------------------------------------------------------------
package vefe_pkg;

  // grid and class limits
  localparam int MAX_DIM     = 1024;
  localparam int CLASS_COUNT = 64;

  // field widths
  localparam int SIZE_W   = 11;
  localparam int POS_W    = 10;
  localparam int CLASS_W  = 6;
  localparam int FACE_W   = 3;
  localparam int CORNER_W = 31;
  localparam int NFACE    = 6;
  localparam int DATA_W   = 64;
  localparam int IDX_W    = 2;

  // derived lattice widths: vic = I+1, vij = (I+1)(J+1)
  localparam int VIC_W = SIZE_W;
  localparam int VIJ_W = 2 * VIC_W - 1;
  localparam int OFF_W = VIJ_W + 1;
  localparam int PKV_W = CORNER_W;
  localparam int PJV_W = POS_W + VIC_W - 1;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SIZE_I = 2'd0,
    REG_SIZE_J = 2'd1,
    REG_SIZE_K = 2'd2,
    REG_MASK   = 2'd3
  } reg_idx_e;

  // face codes, also the emission order
  typedef enum logic [FACE_W-1:0] {
    FACE_BOTTOM = 3'd0,
    FACE_FRONT  = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_TOP    = 3'd3,
    FACE_RIGHT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_e;

  // settled configuration seen by the datapath
  typedef struct packed {
    logic [SIZE_W-1:0]      eff_i;
    logic [SIZE_W-1:0]      eff_j;
    logic [SIZE_W-1:0]      eff_k;
    logic [VIC_W-1:0]       vic;
    logic [VIJ_W-1:0]       vij;
    logic [CLASS_COUNT-1:0] mask;
  } cfg_t;

  // one voxel handed from the front stages to the face emitter
  typedef struct packed {
    logic [NFACE-1:0]   faces;
    logic [CLASS_W-1:0] cls;
    logic [PKV_W-1:0]   pkv;
    logic [PJV_W-1:0]   pjv;
    logic [POS_W-1:0]   pi;
  } job_t;

  // zero counts as one, anything above the grid limit is clamped
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end
    return r;
  endfunction

  // class selected by the filter mask
  function automatic logic class_sel(input logic [CLASS_COUNT-1:0] m,
                                     input logic [CLASS_W-1:0] c);
    return (int'(c) < CLASS_COUNT) && m[c];
  endfunction

endpackage

// ===== src/voxel_exposed_face_extract_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_exposed_face_extract_core
// Emits one quad per exposed face of each selected voxel, in the order
// bottom, front, left, top, right, back, with lattice corner indices.
// ----------------------------------------------------------------------------
// A voxel is taken when start_i is high and busy_o is low. It passes the
// input, classify, emitter and result registers, and its quads show one per
// cycle, each for a single cycle under result_valid_o, last_face_o on the
// final one. The receiver cannot stall. A voxel with quads holds the face
// emitter until its last quad, when the next voxel loads; voxels with no
// quads are dropped before it and pass at one per cycle while the emitter
// does not hold them back. busy_o rises once the two stages before a busy
// emitter are full. Configuration writes are always taken (cfg_ready_o is
// tied high) and must only happen while no voxel is in flight.
// ----------------------------------------------------------------------------
module voxel_exposed_face_extract_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vefe_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [vefe_pkg::DATA_W-1:0]   cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [vefe_pkg::POS_W-1:0]    pos_i_i,
  input  logic [vefe_pkg::POS_W-1:0]    pos_j_i,
  input  logic [vefe_pkg::POS_W-1:0]    pos_k_i,
  input  logic [vefe_pkg::CLASS_W-1:0]  center_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0]  below_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0]  front_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0]  left_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0]  above_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0]  right_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0]  back_class_i,
  output logic                          result_valid_o,
  output logic [vefe_pkg::FACE_W-1:0]   face_code_o,
  output logic [vefe_pkg::CLASS_W-1:0]  quad_class_o,
  output logic [vefe_pkg::CORNER_W-1:0] corner_a_o,
  output logic [vefe_pkg::CORNER_W-1:0] corner_b_o,
  output logic [vefe_pkg::CORNER_W-1:0] corner_c_o,
  output logic [vefe_pkg::CORNER_W-1:0] corner_d_o,
  output logic                          last_face_o
);
  import vefe_pkg::*;

  cfg_t cfg;
  job_t job;
  logic job_valid, job_ready;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  vefe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input and classify stages
  vefe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .pos_i_i        (pos_i_i),
    .pos_j_i        (pos_j_i),
    .pos_k_i        (pos_k_i),
    .center_class_i (center_class_i),
    .below_class_i  (below_class_i),
    .front_class_i  (front_class_i),
    .left_class_i   (left_class_i),
    .above_class_i  (above_class_i),
    .right_class_i  (right_class_i),
    .back_class_i   (back_class_i),
    .job_valid_o    (job_valid),
    .job_o          (job),
    .job_ready_i    (job_ready)
  );

  // face emitter and result register
  vefe_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_ready_o    (job_ready),
    .result_valid_o (result_valid_o),
    .face_code_o    (face_code_o),
    .quad_class_o   (quad_class_o),
    .corner_a_o     (corner_a_o),
    .corner_b_o     (corner_b_o),
    .corner_c_o     (corner_c_o),
    .corner_d_o     (corner_d_o),
    .last_face_o    (last_face_o)
  );

endmodule

// ===== src/vefe_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vefe_cfg
// Configuration registers, size clamping and lattice stride precompute.
// ----------------------------------------------------------------------------
module vefe_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [vefe_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [vefe_pkg::DATA_W-1:0] cfg_data_i,
  output vefe_pkg::cfg_t              cfg_o
);
  import vefe_pkg::*;

  logic [SIZE_W-1:0]      size_i_q, size_j_q, size_k_q;
  logic [CLASS_COUNT-1:0] mask_q;
  logic [VIC_W-1:0]       vic_q, vic_d;
  logic [VIJ_W-1:0]       vij_q, vij_d;
  logic [SIZE_W-1:0]      eff_i, eff_j, eff_k;
  reg_idx_e               idx;

  assign idx = reg_idx_e'(cfg_index_i);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_i_q <= SIZE_W'(1);
      size_j_q <= SIZE_W'(1);
      size_k_q <= SIZE_W'(1);
      mask_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (idx)
        REG_SIZE_I: size_i_q <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_J: size_j_q <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_K: size_k_q <= cfg_data_i[SIZE_W-1:0];
        REG_MASK:   mask_q   <= cfg_data_i[CLASS_COUNT-1:0];
        default:    ;
      endcase
    end
  end

  // clamped sizes
  assign eff_i = eff_size(size_i_q);
  assign eff_j = eff_size(size_j_q);
  assign eff_k = eff_size(size_k_q);

  // lattice strides, one multiply then a register
  assign vic_d = VIC_W'(eff_i) + VIC_W'(1);
  assign vij_d = VIJ_W'(vic_d) * (VIJ_W'(eff_j) + VIJ_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vic_q <= VIC_W'(2);
      vij_q <= VIJ_W'(4);
    end else begin
      vic_q <= vic_d;
      vij_q <= vij_d;
    end
  end

  assign cfg_o.eff_i = eff_i;
  assign cfg_o.eff_j = eff_j;
  assign cfg_o.eff_k = eff_k;
  assign cfg_o.vic   = vic_q;
  assign cfg_o.vij   = vij_q;
  assign cfg_o.mask  = mask_q;

endmodule

// ===== src/vefe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vefe_front
// Input register and classify stage: exposed-face mask and partial
// vertex-index products for each voxel.
// ----------------------------------------------------------------------------
module vefe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vefe_pkg::cfg_t               cfg_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [vefe_pkg::POS_W-1:0]   pos_i_i,
  input  logic [vefe_pkg::POS_W-1:0]   pos_j_i,
  input  logic [vefe_pkg::POS_W-1:0]   pos_k_i,
  input  logic [vefe_pkg::CLASS_W-1:0] center_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0] below_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0] front_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0] left_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0] above_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0] right_class_i,
  input  logic [vefe_pkg::CLASS_W-1:0] back_class_i,
  output logic                         job_valid_o,
  output vefe_pkg::job_t               job_o,
  input  logic                         job_ready_i
);
  import vefe_pkg::*;

  // input register
  logic               in_v_q;
  logic [POS_W-1:0]   pi_q, pj_q, pk_q;
  logic [CLASS_W-1:0] cls_q;
  logic [CLASS_W-1:0] nb_q [NFACE];

  // classify register
  logic               job_v_q;
  job_t               job_q, job_d;

  logic               job_free, in_free, accept;
  logic               in_range;
  logic [NFACE-1:0]   bnd, expo;

  // flow control, each stage moves when the one after it frees up
  assign job_free = !job_v_q || job_ready_i;
  assign in_free  = !in_v_q || job_free;
  assign busy_o   = !in_free;
  assign accept   = start_i && in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_free) begin
      in_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pi_q              <= pos_i_i;
      pj_q              <= pos_j_i;
      pk_q              <= pos_k_i;
      cls_q             <= center_class_i;
      nb_q[FACE_BOTTOM] <= below_class_i;
      nb_q[FACE_FRONT]  <= front_class_i;
      nb_q[FACE_LEFT]   <= left_class_i;
      nb_q[FACE_TOP]    <= above_class_i;
      nb_q[FACE_RIGHT]  <= right_class_i;
      nb_q[FACE_BACK]   <= back_class_i;
    end
  end

  // grid boundary per face
  assign in_range = ({1'b0, pi_q} < cfg_i.eff_i) && ({1'b0, pj_q} < cfg_i.eff_j) &&
                    ({1'b0, pk_q} < cfg_i.eff_k);
  assign bnd[FACE_BOTTOM] = (pk_q == '0);
  assign bnd[FACE_FRONT]  = (pj_q == '0);
  assign bnd[FACE_LEFT]   = (pi_q == '0);
  assign bnd[FACE_TOP]    = ({1'b0, pk_q} == cfg_i.eff_k - SIZE_W'(1));
  assign bnd[FACE_RIGHT]  = ({1'b0, pi_q} == cfg_i.eff_i - SIZE_W'(1));
  assign bnd[FACE_BACK]   = ({1'b0, pj_q} == cfg_i.eff_j - SIZE_W'(1));

  // exposed faces and partial vertex index
  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      expo[f] = bnd[f] || !class_sel(cfg_i.mask, nb_q[f]);
    end
    job_d.faces = (in_range && class_sel(cfg_i.mask, cls_q)) ? expo : '0;
    job_d.cls   = cls_q;
    job_d.pkv   = PKV_W'(PKV_W'(pk_q) * PKV_W'(cfg_i.vij));
    job_d.pjv   = PJV_W'(PJV_W'(pj_q) * PJV_W'(cfg_i.vic));
    job_d.pi    = pi_q;
  end

  // voxels with no quads are dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
    end else if (job_free) begin
      job_v_q <= in_v_q && (job_d.faces != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_free && in_v_q) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_v_q;
  assign job_o       = job_q;

endmodule

// ===== src/vefe_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vefe_emit
// Face emitter: walks the exposed faces of one voxel, one quad per cycle,
// into the result register.
// ----------------------------------------------------------------------------
module vefe_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vefe_pkg::cfg_t                cfg_i,
  input  logic                          job_valid_i,
  input  vefe_pkg::job_t                job_i,
  output logic                          job_ready_o,
  output logic                          result_valid_o,
  output logic [vefe_pkg::FACE_W-1:0]   face_code_o,
  output logic [vefe_pkg::CLASS_W-1:0]  quad_class_o,
  output logic [vefe_pkg::CORNER_W-1:0] corner_a_o,
  output logic [vefe_pkg::CORNER_W-1:0] corner_b_o,
  output logic [vefe_pkg::CORNER_W-1:0] corner_c_o,
  output logic [vefe_pkg::CORNER_W-1:0] corner_d_o,
  output logic                          last_face_o
);
  import vefe_pkg::*;

  logic [NFACE-1:0]    rem_q, rem_nxt;
  logic [CLASS_W-1:0]  cls_q;
  logic [CORNER_W-1:0] v_q, v_d;
  face_e               cur;
  logic                emit;
  logic [OFF_W-1:0]    off [4];
  logic [OFF_W-1:0]    vic, vij;

  logic                res_v_q;
  logic [FACE_W-1:0]   face_q;
  logic [CLASS_W-1:0]  rcls_q;
  logic [CORNER_W-1:0] corner_q [4];
  logic                last_q;

  // lowest pending face goes out first
  always_comb begin
    cur = FACE_BACK;
    for (int f = NFACE - 1; f >= 0; f--) begin
      if (rem_q[f]) begin
        cur = face_e'(FACE_W'(f));
      end
    end
  end

  assign emit        = (rem_q != '0);
  assign rem_nxt     = rem_q & (rem_q - NFACE'(1));
  assign job_ready_o = (rem_nxt == '0);

  // base vertex of the voxel
  assign v_d = job_i.pkv + CORNER_W'(job_i.pjv) + CORNER_W'(job_i.pi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (job_ready_o && job_valid_i) begin
      rem_q <= job_i.faces;
    end else begin
      rem_q <= rem_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) begin
      v_q   <= v_d;
      cls_q <= job_i.cls;
    end
  end

  // corner offsets on the vertex lattice
  assign vic = OFF_W'(cfg_i.vic);
  assign vij = OFF_W'(cfg_i.vij);

  always_comb begin
    off[0] = '0;
    off[1] = OFF_W'(1);
    off[2] = vic + OFF_W'(1);
    off[3] = vic;
    case (cur)
      FACE_BOTTOM: begin
        off[0] = '0;
        off[1] = OFF_W'(1);
        off[2] = vic + OFF_W'(1);
        off[3] = vic;
      end
      FACE_FRONT: begin
        off[0] = '0;
        off[1] = OFF_W'(1);
        off[2] = vij + OFF_W'(1);
        off[3] = vij;
      end
      FACE_LEFT: begin
        off[0] = '0;
        off[1] = vic;
        off[2] = vic + vij;
        off[3] = vij;
      end
      FACE_TOP: begin
        off[0] = vij;
        off[1] = vij + OFF_W'(1);
        off[2] = vij + vic + OFF_W'(1);
        off[3] = vij + vic;
      end
      FACE_RIGHT: begin
        off[0] = OFF_W'(1);
        off[1] = vic + OFF_W'(1);
        off[2] = vij + vic + OFF_W'(1);
        off[3] = vij + OFF_W'(1);
      end
      FACE_BACK: begin
        off[0] = vic;
        off[1] = vic + OFF_W'(1);
        off[2] = vij + vic + OFF_W'(1);
        off[3] = vij + vic;
      end
      default: ;
    endcase
  end

  // result register, one quad per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      face_q <= cur;
      rcls_q <= cls_q;
      last_q <= (rem_nxt == '0);
      for (int q = 0; q < 4; q++) begin
        corner_q[q] <= v_q + CORNER_W'(off[q]);
      end
    end
  end

  assign result_valid_o = res_v_q;
  assign face_code_o    = face_q;
  assign quad_class_o   = rcls_q;
  assign corner_a_o     = corner_q[0];
  assign corner_b_o     = corner_q[1];
  assign corner_c_o     = corner_q[2];
  assign corner_d_o     = corner_q[3];
  assign last_face_o    = last_q;

endmodule

// ===== src/vefe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vefe_checker
// Port-level checks on the quad stream of the face extractor.
// ----------------------------------------------------------------------------
module vefe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          result_valid_o,
  input logic [vefe_pkg::FACE_W-1:0]   face_code_o,
  input logic [vefe_pkg::CLASS_W-1:0]  quad_class_o,
  input logic [vefe_pkg::CORNER_W-1:0] corner_a_o,
  input logic [vefe_pkg::CORNER_W-1:0] corner_b_o,
  input logic                          last_face_o
);
  import vefe_pkg::*;

  // quads of one voxel come out back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_face_o |=> result_valid_o)
    else $error("quad burst broken before last face");

  // faces of one voxel rise strictly in code order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_face_o |=> face_code_o > $past(face_code_o))
    else $error("face order violated");

  // class is constant across one voxel's quads
  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_face_o |=> quad_class_o == $past(quad_class_o))
    else $error("quad class changed inside a voxel");

  // faces lying along the i axis have their first two corners adjacent in i
  a_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (face_code_o == FACE_BOTTOM || face_code_o == FACE_FRONT ||
                       face_code_o == FACE_TOP || face_code_o == FACE_BACK)
    |-> corner_b_o == corner_a_o + CORNER_W'(1))
    else $error("corner b not next to corner a");

endmodule

bind voxel_exposed_face_extract_core vefe_checker u_vefe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .face_code_o    (face_code_o),
  .quad_class_o   (quad_class_o),
  .corner_a_o     (corner_a_o),
  .corner_b_o     (corner_b_o),
  .last_face_o    (last_face_o)
);

// ===== tb/sv/quad_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_check_pkg
// Voxel and quad records plus the scoreboard that predicts the quads of each
// accepted voxel and checks the quads coming out of the extractor.
// ----------------------------------------------------------------------------
package quad_check_pkg;
  import vefe_pkg::*;

  // one voxel as driven on the input ports
  typedef struct packed {
    logic [POS_W-1:0]                  pos_i;
    logic [POS_W-1:0]                  pos_j;
    logic [POS_W-1:0]                  pos_k;
    logic [CLASS_W-1:0]                center;
    logic [NFACE-1:0][CLASS_W-1:0]     nbr;
  } voxel_t;

  // one quad as seen on the result ports
  typedef struct packed {
    logic [FACE_W-1:0]                 face;
    logic [CLASS_W-1:0]                cls;
    logic [3:0][CORNER_W-1:0]          corner;
    logic                              last;
  } quad_t;

  class quad_scoreboard;
    quad_t             pending[$];
    logic [SIZE_W-1:0] size_word[3] = '{SIZE_W'(1), SIZE_W'(1), SIZE_W'(1)};
    logic [DATA_W-1:0] mask         = '0;
    int                errors       = 0;

    // register write as taken by the block
    function void set_reg(reg_idx_e idx, logic [DATA_W-1:0] data);
      if (idx == REG_MASK) begin
        mask = data;
      end else begin
        size_word[idx] = data[SIZE_W-1:0];
      end
    endfunction

    // voxel count along one axis after clamping
    function int unsigned extent(reg_idx_e axis);
      int unsigned s;
      s = size_word[axis];
      if (s == 0) begin
        s = 1;
      end else if (s > MAX_DIM) begin
        s = MAX_DIM;
      end
      return s;
    endfunction

    function bit class_on(logic [CLASS_W-1:0] c);
      return (int'(c) < CLASS_COUNT) && mask[c];
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // work out the quads of an accepted voxel
    function void note_voxel(voxel_t vx);
      longint unsigned si, sj, sk, vic, vij, base;
      longint unsigned off[NFACE][4];
      bit              at_rim[NFACE];
      quad_t           q;
      int              count;
      si = extent(REG_SIZE_I);
      sj = extent(REG_SIZE_J);
      sk = extent(REG_SIZE_K);
      if (vx.pos_i >= si || vx.pos_j >= sj || vx.pos_k >= sk) return;
      if (!class_on(vx.center)) return;
      at_rim[FACE_BOTTOM] = (vx.pos_k == 0);
      at_rim[FACE_FRONT]  = (vx.pos_j == 0);
      at_rim[FACE_LEFT]   = (vx.pos_i == 0);
      at_rim[FACE_TOP]    = (vx.pos_k == sk - 1);
      at_rim[FACE_RIGHT]  = (vx.pos_i == si - 1);
      at_rim[FACE_BACK]   = (vx.pos_j == sj - 1);
      // lattice strides and the voxel's lowest corner
      vic  = si + 1;
      vij  = vic * (sj + 1);
      base = vx.pos_k * vij + vx.pos_j * vic + vx.pos_i;
      off[FACE_BOTTOM] = '{0, 1, vic + 1, vic};
      off[FACE_FRONT]  = '{0, 1, vij + 1, vij};
      off[FACE_LEFT]   = '{0, vic, vic + vij, vij};
      off[FACE_TOP]    = '{vij, vij + 1, vij + vic + 1, vij + vic};
      off[FACE_RIGHT]  = '{1, vic + 1, vij + vic + 1, vij + 1};
      off[FACE_BACK]   = '{vic, vic + 1, vij + vic + 1, vij + vic};
      count = 0;
      for (int f = 0; f < NFACE; f++) begin
        if (at_rim[f] || !class_on(vx.nbr[f])) begin
          q.face = face_e'(f);
          q.cls  = vx.center;
          for (int c = 0; c < 4; c++) begin
            q.corner[c] = CORNER_W'(base + off[f][c]);
          end
          q.last = 1'b0;
          pending = {pending, q};
          count++;
        end
      end
      if (count > 0) pending[pending.size() - 1].last = 1'b1;
    endfunction

    // compare a quad from the block with the oldest prediction
    function void check_quad(quad_t got);
      quad_t want;
      if (pending.size() == 0) begin
        $error("unexpected quad: face_code %0d, quad_class %0d", got.face, got.cls);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.face !== want.face) begin
        $error("face_code: expected %0d, got %0d", want.face, got.face);
        errors++;
      end
      if (got.cls !== want.cls) begin
        $error("quad_class: expected %0d, got %0d", want.cls, got.cls);
        errors++;
      end
      if (got.corner[0] !== want.corner[0]) begin
        $error("corner_a: expected %0d, got %0d", want.corner[0], got.corner[0]);
        errors++;
      end
      if (got.corner[1] !== want.corner[1]) begin
        $error("corner_b: expected %0d, got %0d", want.corner[1], got.corner[1]);
        errors++;
      end
      if (got.corner[2] !== want.corner[2]) begin
        $error("corner_c: expected %0d, got %0d", want.corner[2], got.corner[2]);
        errors++;
      end
      if (got.corner[3] !== want.corner[3]) begin
        $error("corner_d: expected %0d, got %0d", want.corner[3], got.corner[3]);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_face: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives voxels into the exposed-face extractor under several grid sizes and
// class masks, directed corner cases first and random voxels after, and
// checks every emitted quad against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;
  import vefe_pkg::*;
  import quad_check_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [IDX_W-1:0]    cfg_index_i    = '0;
  logic [DATA_W-1:0]   cfg_data_i     = '0;
  logic                start_i        = 1'b0;
  logic                busy_o;
  logic [POS_W-1:0]    pos_i_i        = '0;
  logic [POS_W-1:0]    pos_j_i        = '0;
  logic [POS_W-1:0]    pos_k_i        = '0;
  logic [CLASS_W-1:0]  center_class_i = '0;
  logic [CLASS_W-1:0]  below_class_i  = '0;
  logic [CLASS_W-1:0]  front_class_i  = '0;
  logic [CLASS_W-1:0]  left_class_i   = '0;
  logic [CLASS_W-1:0]  above_class_i  = '0;
  logic [CLASS_W-1:0]  right_class_i  = '0;
  logic [CLASS_W-1:0]  back_class_i   = '0;
  logic                result_valid_o;
  logic [FACE_W-1:0]   face_code_o;
  logic [CLASS_W-1:0]  quad_class_o;
  logic [CORNER_W-1:0] corner_a_o;
  logic [CORNER_W-1:0] corner_b_o;
  logic [CORNER_W-1:0] corner_c_o;
  logic [CORNER_W-1:0] corner_d_o;
  logic                last_face_o;

  quad_scoreboard sb = new();
  bit             calm = 1'b0;
  int             cycles = 0;

  voxel_exposed_face_extract_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .pos_i_i        (pos_i_i),
    .pos_j_i        (pos_j_i),
    .pos_k_i        (pos_k_i),
    .center_class_i (center_class_i),
    .below_class_i  (below_class_i),
    .front_class_i  (front_class_i),
    .left_class_i   (left_class_i),
    .above_class_i  (above_class_i),
    .right_class_i  (right_class_i),
    .back_class_i   (back_class_i),
    .result_valid_o (result_valid_o),
    .face_code_o    (face_code_o),
    .quad_class_o   (quad_class_o),
    .corner_a_o     (corner_a_o),
    .corner_b_o     (corner_b_o),
    .corner_c_o     (corner_c_o),
    .corner_d_o     (corner_d_o),
    .last_face_o    (last_face_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // quad monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_quad('{face: face_code_o, cls: quad_class_o,
                      corner: {corner_d_o, corner_c_o, corner_b_o, corner_a_o},
                      last: last_face_o});
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic voxel_t make_voxel(int pi, int pj, int pk, int cls,
                                        logic [NFACE-1:0][CLASS_W-1:0] nbr);
    voxel_t vx;
    vx.pos_i  = POS_W'(pi);
    vx.pos_j  = POS_W'(pj);
    vx.pos_k  = POS_W'(pk);
    vx.center = CLASS_W'(cls);
    vx.nbr    = nbr;
    return vx;
  endfunction

  // position on one axis, often on the rims, sometimes off the grid
  function automatic logic [POS_W-1:0] pick_pos(int unsigned ext);
    case ($urandom_range(9))
      0:       return POS_W'($urandom_range(1023));
      1, 2:    return '0;
      3, 4:    return POS_W'(ext - 1);
      default: return POS_W'($urandom_range(ext - 1));
    endcase
  endfunction

  // class code, leaning toward selected ones by the given percentage
  function automatic logic [CLASS_W-1:0] pick_class(int lean);
    logic [CLASS_W-1:0] c;
    c = CLASS_W'($urandom_range(63));
    if ($urandom_range(99) < lean) begin
      for (int n = 0; n < 32 && !sb.class_on(c); n++) c = CLASS_W'($urandom_range(63));
    end
    return c;
  endfunction

  function automatic voxel_t random_voxel();
    voxel_t vx;
    vx.pos_i  = pick_pos(sb.extent(REG_SIZE_I));
    vx.pos_j  = pick_pos(sb.extent(REG_SIZE_J));
    vx.pos_k  = pick_pos(sb.extent(REG_SIZE_K));
    vx.center = pick_class(85);
    for (int f = 0; f < NFACE; f++) vx.nbr[f] = pick_class(50);
    return vx;
  endfunction

  // size word with random upper bits, often zero, clamped or tiny
  function automatic logic [DATA_W-1:0] pick_size_word();
    logic [DATA_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       w[SIZE_W-1:0] = '0;
      1:       w[SIZE_W-1:0] = SIZE_W'(1);
      2:       w[SIZE_W-1:0] = SIZE_W'(MAX_DIM);
      3:       w[SIZE_W-1:0] = '1;
      4:       ;
      default: w[SIZE_W-1:0] = SIZE_W'($urandom_range(2, 9));
    endcase
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] pick_mask();
    case ($urandom_range(5))
      0:       return '1;
      1:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one voxel transaction, with random gaps before it
  task automatic send_voxel(voxel_t vx);
    while (!calm && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    pos_i_i        <= vx.pos_i;
    pos_j_i        <= vx.pos_j;
    pos_k_i        <= vx.pos_k;
    center_class_i <= vx.center;
    below_class_i  <= vx.nbr[FACE_BOTTOM];
    front_class_i  <= vx.nbr[FACE_FRONT];
    left_class_i   <= vx.nbr[FACE_LEFT];
    above_class_i  <= vx.nbr[FACE_TOP];
    right_class_i  <= vx.nbr[FACE_RIGHT];
    back_class_i   <= vx.nbr[FACE_BACK];
    do @(posedge clk_i); while (busy_o);
    sb.note_voxel(vx);
  endtask

  // stop feeding, wait for every quad and for voxels that yield none
  task automatic settle_block();
    start_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(logic [DATA_W-1:0] si, logic [DATA_W-1:0] sj,
                              logic [DATA_W-1:0] sk, logic [DATA_W-1:0] m);
    settle_block();
    write_reg(REG_SIZE_I, si);
    write_reg(REG_SIZE_J, sj);
    write_reg(REG_SIZE_K, sk);
    write_reg(REG_MASK, m);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: nothing is selected
    send_voxel(make_voxel(0, 0, 0, 0, '0));

    // zero sizes act as one, every class selected
    apply_config(64'd0, 64'd0, 64'd0, '1);
    send_voxel(make_voxel(0, 0, 0, 63, '0));
    send_voxel(make_voxel(1, 0, 0, 63, '0));
    send_voxel(make_voxel(0, 0, 1, 63, '0));

    // oversize clamps to the full grid, even classes selected
    apply_config({53'h1, 11'h7FF}, 64'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555);
    send_voxel(make_voxel(1023, 1023, 1023, 0, {6{6'd2}}));
    send_voxel(make_voxel(0, 0, 0, 62, {6{6'd1}}));
    send_voxel(make_voxel(500, 600, 700, 2, {6{6'd4}}));
    send_voxel(make_voxel(500, 600, 700, 2, {6{6'd3}}));
    send_voxel(make_voxel(500, 600, 700, 1, {6{6'd3}}));
    send_voxel(make_voxel(500, 600, 700, 0, {6'd60, 6'd61, 6'd62, 6'd63, 6'd0, 6'd1}));
    send_voxel(make_voxel(1023, 0, 512, 6, {6'd11, 6'd9, 6'd7, 6'd5, 6'd3, 6'd1}));
    send_voxel(make_voxel(1023, 1023, 0, 60, {6{6'd63}}));

    // small odd grid, only the lowest and highest classes selected
    apply_config({53'h1A_5A5A_5A5A_5A5A, 11'd3}, {53'h15_0F0F_0F0F_0F0F, 11'd2},
                 64'hFFFF_FFFF_FFFF_F805, 64'h8000_0000_0000_0001);
    send_voxel(make_voxel(1, 0, 2, 63, '0));
    send_voxel(make_voxel(2, 1, 4, 0, {6{6'd5}}));
    send_voxel(make_voxel(3, 0, 0, 0, '0));
    send_voxel(make_voxel(0, 2, 0, 0, '0));
    send_voxel(make_voxel(0, 0, 5, 0, '0));
    send_voxel(make_voxel(1, 1, 1, 63, {6{6'd63}}));

    // random phases, one of them without any input gaps
    for (int ph = 0; ph < 8; ph++) begin
      apply_config(pick_size_word(), pick_size_word(), pick_size_word(), pick_mask());
      calm = (ph == 3);
      for (int n = 0; n < 56; n++) send_voxel(random_voxel());
    end
    calm = 1'b0;

    settle_block();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
